[rtl/gtp_pkg.sv]
`timescale 1ns / 1ps

package gtp_pkg;

  // Number of compare channels that have registers.
  localparam int unsigned NumCh = 4;

  // Item kinds carried by the mode field.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register word indexes.
  localparam logic [4:0] REG_CR1   = 5'd0;
  localparam logic [4:0] REG_DIER  = 5'd3;
  localparam logic [4:0] REG_SR    = 5'd4;
  localparam logic [4:0] REG_EGR   = 5'd5;
  localparam logic [4:0] REG_CCMR1 = 5'd6;
  localparam logic [4:0] REG_CCMR2 = 5'd7;
  localparam logic [4:0] REG_CCER  = 5'd8;
  localparam logic [4:0] REG_CNT   = 5'd9;
  localparam logic [4:0] REG_PSC   = 5'd10;
  localparam logic [4:0] REG_ARR   = 5'd11;
  localparam logic [4:0] REG_CCR1  = 5'd13;
  localparam logic [4:0] REG_CCR4  = 5'd16;

  // Output compare mode code for PWM mode 1.
  localparam logic [2:0] PWM_MODE_ONE = 3'd6;

  // Per-item results of the register and counter step.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        update_event;
  } gtp_step_t;

endpackage

[rtl/gtp_if.sv]
`timescale 1ns / 1ps

// Input channel: one tick, register read or register write per beat.
interface gtp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [4:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, output mode, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

// Output channel: one result per input beat.
interface gtp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_request;
  logic [3:0]  pwm_out;
  logic        update_event;

  modport source (output valid, output read_data, output irq_request, output pwm_out,
                  output update_event, input ready);
  modport sink   (input valid, input read_data, input irq_request, input pwm_out,
                  input update_event, output ready);
endinterface

[rtl/gtp_regs.sv]
`timescale 1ns / 1ps

// Register file, prescaler and counter. One item is applied when step_i is high;
// the next-state values are exported so results reflect the state after the item.
module gtp_regs #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [1:0]             mode_i,
  input  logic [4:0]             reg_index_i,
  input  logic [31:0]            write_data_i,
  output gtp_pkg::gtp_step_t     step_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic [COUNT_WIDTH-1:0] ccr_o [gtp_pkg::NumCh],
  output logic [7:0]             ccm_o [gtp_pkg::NumCh],
  output logic [15:0]            ccer_o
);

  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  logic                   cen_q, cen_d, urs_q, urs_d, opm_q, opm_d, arpe_q, arpe_d;
  logic                   uie_q, uie_d, uif_q, uif_d;
  logic [7:0]             ccm_q [gtp_pkg::NumCh];
  logic [7:0]             ccm_d [gtp_pkg::NumCh];
  logic [15:0]            ccer_q, ccer_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [15:0]            psc_pre_q, psc_pre_d, psc_sh_q, psc_sh_d, psc_cnt_q, psc_cnt_d;
  logic [COUNT_WIDTH-1:0] arr_pre_q, arr_pre_d, arr_sh_q, arr_sh_d;
  logic [COUNT_WIDTH-1:0] ccr_pre_q [gtp_pkg::NumCh];
  logic [COUNT_WIDTH-1:0] ccr_pre_d [gtp_pkg::NumCh];
  logic [COUNT_WIDTH-1:0] ccr_sh_q [gtp_pkg::NumCh];
  logic [COUNT_WIDTH-1:0] ccr_sh_d [gtp_pkg::NumCh];
  logic [4:0]             ccr_off;
  logic [1:0]             ch;
  logic [31:0]            rd;
  logic                   upd;

  assign ccr_off = reg_index_i - gtp_pkg::REG_CCR1;
  assign ch      = ccr_off[1:0];

  // Next state and per-item results.
  always_comb begin
    cen_d     = cen_q;
    urs_d     = urs_q;
    opm_d     = opm_q;
    arpe_d    = arpe_q;
    uie_d     = uie_q;
    uif_d     = uif_q;
    ccm_d     = ccm_q;
    ccer_d    = ccer_q;
    cnt_d     = cnt_q;
    psc_pre_d = psc_pre_q;
    psc_sh_d  = psc_sh_q;
    psc_cnt_d = psc_cnt_q;
    arr_pre_d = arr_pre_q;
    arr_sh_d  = arr_sh_q;
    ccr_pre_d = ccr_pre_q;
    ccr_sh_d  = ccr_sh_q;
    rd        = '0;
    upd       = 1'b0;
    if (step_i) begin
      case (mode_i)
        gtp_pkg::MODE_TICK: begin
          if (cen_q) begin
            if (psc_cnt_q < psc_sh_q) begin
              psc_cnt_d = psc_cnt_q + 16'd1;
            end else begin
              psc_cnt_d = '0;
              if (cnt_q == arr_sh_q || cnt_q == '1) begin
                // Overflow: update event, reload shadows.
                cnt_d    = '0;
                psc_sh_d = psc_pre_q;
                arr_sh_d = arr_pre_q;
                ccr_sh_d = ccr_pre_q;
                uif_d    = 1'b1;
                upd      = 1'b1;
                if (opm_q) begin
                  cen_d = 1'b0;
                end
              end else begin
                cnt_d = cnt_q + CntOne;
              end
            end
          end
        end
        gtp_pkg::MODE_READ: begin
          case (reg_index_i) inside
            gtp_pkg::REG_CR1:   rd = {24'd0, arpe_q, 3'd0, opm_q, urs_q, 1'b0, cen_q};
            gtp_pkg::REG_DIER:  rd = {31'd0, uie_q};
            gtp_pkg::REG_SR:    rd = {31'd0, uif_q};
            gtp_pkg::REG_CCMR1: rd = {16'd0, ccm_q[1], ccm_q[0]};
            gtp_pkg::REG_CCMR2: rd = {16'd0, ccm_q[3], ccm_q[2]};
            gtp_pkg::REG_CCER:  rd = {16'd0, ccer_q};
            gtp_pkg::REG_CNT:   rd = 32'(cnt_q);
            gtp_pkg::REG_PSC:   rd = {16'd0, psc_pre_q};
            gtp_pkg::REG_ARR:   rd = 32'(arr_pre_q);
            [gtp_pkg::REG_CCR1:gtp_pkg::REG_CCR4]: rd = 32'(ccr_pre_q[ch]);
            default:            rd = '0;
          endcase
        end
        gtp_pkg::MODE_WRITE: begin
          case (reg_index_i) inside
            gtp_pkg::REG_CR1: begin
              cen_d  = write_data_i[0];
              urs_d  = write_data_i[2];
              opm_d  = write_data_i[3];
              arpe_d = write_data_i[7];
            end
            gtp_pkg::REG_DIER: uie_d = write_data_i[0];
            gtp_pkg::REG_SR:   uif_d = uif_q & write_data_i[0];
            gtp_pkg::REG_EGR: begin
              // Software update event also clears the counter.
              if (write_data_i[0]) begin
                psc_sh_d  = psc_pre_q;
                psc_cnt_d = '0;
                arr_sh_d  = arr_pre_q;
                ccr_sh_d  = ccr_pre_q;
                cnt_d     = '0;
                upd       = 1'b1;
                if (!urs_q) begin
                  uif_d = 1'b1;
                end
              end
            end
            gtp_pkg::REG_CCMR1: begin
              ccm_d[0] = write_data_i[7:0];
              ccm_d[1] = write_data_i[15:8];
            end
            gtp_pkg::REG_CCMR2: begin
              ccm_d[2] = write_data_i[7:0];
              ccm_d[3] = write_data_i[15:8];
            end
            gtp_pkg::REG_CCER: ccer_d    = write_data_i[15:0];
            gtp_pkg::REG_CNT:  cnt_d     = write_data_i[COUNT_WIDTH-1:0];
            gtp_pkg::REG_PSC:  psc_pre_d = write_data_i[15:0];
            gtp_pkg::REG_ARR: begin
              arr_pre_d = write_data_i[COUNT_WIDTH-1:0];
              if (!arpe_q) begin
                arr_sh_d = write_data_i[COUNT_WIDTH-1:0];
              end
            end
            [gtp_pkg::REG_CCR1:gtp_pkg::REG_CCR4]: begin
              ccr_pre_d[ch] = write_data_i[COUNT_WIDTH-1:0];
              if (!ccm_q[ch][3]) begin
                ccr_sh_d[ch] = write_data_i[COUNT_WIDTH-1:0];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q     <= 1'b0;
      urs_q     <= 1'b0;
      opm_q     <= 1'b0;
      arpe_q    <= 1'b0;
      uie_q     <= 1'b0;
      uif_q     <= 1'b0;
      ccer_q    <= '0;
      cnt_q     <= '0;
      psc_pre_q <= '0;
      psc_sh_q  <= '0;
      psc_cnt_q <= '0;
      arr_pre_q <= '1;
      arr_sh_q  <= '1;
      for (int i = 0; i < gtp_pkg::NumCh; i++) begin
        ccm_q[i]     <= '0;
        ccr_pre_q[i] <= '0;
        ccr_sh_q[i]  <= '0;
      end
    end else begin
      cen_q     <= cen_d;
      urs_q     <= urs_d;
      opm_q     <= opm_d;
      arpe_q    <= arpe_d;
      uie_q     <= uie_d;
      uif_q     <= uif_d;
      ccer_q    <= ccer_d;
      cnt_q     <= cnt_d;
      psc_pre_q <= psc_pre_d;
      psc_sh_q  <= psc_sh_d;
      psc_cnt_q <= psc_cnt_d;
      arr_pre_q <= arr_pre_d;
      arr_sh_q  <= arr_sh_d;
      ccm_q     <= ccm_d;
      ccr_pre_q <= ccr_pre_d;
      ccr_sh_q  <= ccr_sh_d;
    end
  end

  assign step_o.read_data    = rd;
  assign step_o.irq_request  = uif_d & uie_d;
  assign step_o.update_event = upd;
  assign cnt_o  = cnt_d;
  assign ccr_o  = ccr_sh_d;
  assign ccm_o  = ccm_d;
  assign ccer_o = ccer_d;

endmodule

[rtl/gtp_pwm.sv]
`timescale 1ns / 1ps

// Compare channels: PWM mode 1 reference, polarity and output enable.
module gtp_pwm #(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  input  logic [COUNT_WIDTH-1:0] ccr_i [gtp_pkg::NumCh],
  input  logic [7:0]             ccm_i [gtp_pkg::NumCh],
  input  logic [15:0]            ccer_i,
  output logic [3:0]             pwm_o
);

  logic [gtp_pkg::NumCh-1:0] ref_lvl;

  // Channels past CHANNEL_COUNT keep their registers but drive low.
  always_comb begin
    for (int i = 0; i < gtp_pkg::NumCh; i++) begin
      ref_lvl[i] = (ccm_i[i][6:4] == gtp_pkg::PWM_MODE_ONE) && (cnt_i < ccr_i[i]);
      if (i < CHANNEL_COUNT) begin
        pwm_o[i] = ccer_i[4*i] & (ref_lvl[i] ^ ccer_i[4*i+1]);
      end else begin
        pwm_o[i] = 1'b0;
      end
    end
  end

endmodule

[rtl/general_timer_with_pwm_unit.sv]
`timescale 1ns / 1ps

// Up-counting timer with prescaler, auto-reload, update interrupt request and
// four PWM compare channels. Each input beat is one timer tick, one register
// read or one register write, and yields exactly one output beat carrying the
// read data and the interrupt, PWM and update levels after that beat. One beat
// is taken every clock cycle while the output is not stalled. A beat passes an
// input register and then a result register. The rate is set by the
// combinational step through the register file, counter and compare logic.
module general_timer_with_pwm_unit #(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gtp_in_if.sink   in_i,
  gtp_out_if.source out_o
);

  logic               in_vld_q;
  logic [1:0]         mode_q;
  logic [4:0]         idx_q;
  logic [31:0]        data_q;
  logic               fire;
  logic               out_vld_q, out_vld_d;
  gtp_pkg::gtp_step_t step;
  gtp_pkg::gtp_step_t res_q;
  logic [3:0]         pwm;
  logic [3:0]         pwm_q;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] ccr [gtp_pkg::NumCh];
  logic [7:0]             ccm [gtp_pkg::NumCh];
  logic [15:0]            ccer;

  // The input register moves on when the result register is free or draining.
  assign fire       = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | fire;
  assign out_vld_d  = fire | (out_vld_q & ~out_o.ready);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mode_q <= in_i.mode;
      idx_q  <= in_i.reg_index;
      data_q <= in_i.write_data;
    end
  end

  gtp_regs #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .mode_i      (mode_q),
    .reg_index_i (idx_q),
    .write_data_i(data_q),
    .step_o      (step),
    .cnt_o       (cnt),
    .ccr_o       (ccr),
    .ccm_o       (ccm),
    .ccer_o      (ccer)
  );

  gtp_pwm #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_pwm (
    .cnt_i (cnt),
    .ccr_i (ccr),
    .ccm_i (ccm),
    .ccer_i(ccer),
    .pwm_o (pwm)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= step;
      pwm_q <= pwm;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.read_data    = res_q.read_data;
  assign out_o.irq_request  = res_q.irq_request;
  assign out_o.update_event = res_q.update_event;
  assign out_o.pwm_out      = pwm_q;

endmodule
